@@ rtl/core/t3ls_pkg.sv @@
// Package for the transposed 3x3 linear solver: widths, the shared job type and constants.
// No dependencies.
`default_nettype none
package t3ls_pkg;
    localparam int DATA_W = 32;
    localparam int PROD_W = 97;
    localparam int DEFAULT_FRAC_BITS = 16;

    // Work handed from the front stage to the divide back end.
    typedef struct packed {
        logic signed [PROD_W-1:0] det;
        logic signed [PROD_W-1:0] num0;
        logic signed [PROD_W-1:0] num1;
        logic signed [PROD_W-1:0] num2;
    } t3ls_job_t;
endpackage
`default_nettype wire

@@ rtl/core/t3ls_front.sv @@
// Front end: forms the determinant and the three Cramer numerators.
// Depends on t3ls_pkg. Pipelined: 32x32 products, split third-factor products, merge, sums.
`default_nettype none
module t3ls_front
    import t3ls_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire signed [DATA_W-1:0] m [9],
    input  wire signed [DATA_W-1:0] b [3],
    output logic                    job_valid,
    input  wire                     job_ready,
    output t3ls_job_t               job
);
    // Columns of the determinant matrix (matrix T = transpose(M)): T[r][c] = m[3c+r].
    // det(T) = det(M); numerator k replaces column k of T, i.e. row k of M, by b.
    // Four determinants, each six terms a*b*c.
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [63:0]       p1_reg [4][6];
    logic signed [DATA_W-1:0] f3_reg [4][6];
    logic signed [63:0]       hi_reg [4][6];
    logic signed [64:0]       lo_reg [4][6];
    logic signed [PROD_W-1:0] p2_reg [4][6];
    logic signed [PROD_W-1:0] sum_reg [4];
    logic                     adv;

    assign adv      = !s4_valid_reg || job_ready;
    assign in_ready = adv;

    // Matrix element for determinant d, row i, column j of M (already transposed view).
    function automatic logic signed [DATA_W-1:0] el(input int d, input int i, input int j,
        input logic signed [DATA_W-1:0] mm [9], input logic signed [DATA_W-1:0] bb [3]);
        logic signed [DATA_W-1:0] v;
        begin
            v = mm[3*i+j];
            if (d > 0 && i == d-1)
                v = bb[j];
            el = v;
        end
    endfunction

    // Signed 32x32 product at full width.
    function automatic logic signed [63:0] mul32(input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] y);
        begin
            mul32 = 64'(x) * 64'(y);
        end
    endfunction

    // Stage 1: pairwise products; det(M) expanded along rows.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 4; d++)
            begin
                p1_reg[d][0] <= mul32(el(d,0,0,m,b), el(d,1,1,m,b));
                f3_reg[d][0] <= el(d,2,2,m,b);
                p1_reg[d][1] <= mul32(el(d,0,0,m,b), el(d,1,2,m,b));
                f3_reg[d][1] <= el(d,2,1,m,b);
                p1_reg[d][2] <= mul32(el(d,0,1,m,b), el(d,1,0,m,b));
                f3_reg[d][2] <= el(d,2,2,m,b);
                p1_reg[d][3] <= mul32(el(d,0,1,m,b), el(d,1,2,m,b));
                f3_reg[d][3] <= el(d,2,0,m,b);
                p1_reg[d][4] <= mul32(el(d,0,2,m,b), el(d,1,0,m,b));
                f3_reg[d][4] <= el(d,2,1,m,b);
                p1_reg[d][5] <= mul32(el(d,0,2,m,b), el(d,1,1,m,b));
                f3_reg[d][5] <= el(d,2,0,m,b);
            end
        end
    end

    // Stage 2: third factor times the signed upper and unsigned lower halves of the pair.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 4; d++)
                for (int t = 0; t < 6; t++)
                begin
                    hi_reg[d][t] <= mul32(p1_reg[d][t][63:32], f3_reg[d][t]);
                    lo_reg[d][t] <= 65'($signed({1'b0, p1_reg[d][t][31:0]}))
                                  * 65'(f3_reg[d][t]);
                end
        end
    end

    // Stage 3: merge the two halves into one exact triple product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 4; d++)
                for (int t = 0; t < 6; t++)
                    p2_reg[d][t] <= (PROD_W'(hi_reg[d][t]) <<< 32) + PROD_W'(lo_reg[d][t]);
        end
    end

    // Stage 4: signed sum of six terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 4; d++)
                sum_reg[d] <= p2_reg[d][0] - p2_reg[d][1] - p2_reg[d][2]
                            + p2_reg[d][3] + p2_reg[d][4] - p2_reg[d][5];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign job_valid = s4_valid_reg;
    assign job.det   = sum_reg[0];
    assign job.num0  = sum_reg[1];
    assign job.num1  = sum_reg[2];
    assign job.num2  = sum_reg[3];
endmodule
`default_nettype wire

@@ rtl/core/t3ls_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on t3ls_pkg.
`default_nettype none
module t3ls_queue
    import t3ls_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_valid,
    output logic       wr_ready,
    input  t3ls_job_t  wr_data,
    output logic       rd_valid,
    input  wire        rd_ready,
    output t3ls_job_t  rd_data
);
    t3ls_job_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/t3ls_back.sv @@
// Back end: pipelined restoring dividers, one quotient bit per stage, plus saturation.
// Depends on t3ls_pkg.
`default_nettype none
module t3ls_back
    import t3ls_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     job_valid,
    output logic                    job_ready,
    input  t3ls_job_t               job,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic signed [DATA_W-1:0] sol [3],
    output logic                    singular,
    output logic                    saturated
);
    // Only quotient magnitudes up to 2^31 matter; larger ones saturate.
    // Quotient bits 32 and up are detected up front: |n|*2^F >= |d|*2^32.
    localparam int QB   = DATA_W;
    localparam int MAGW = PROD_W - 1;
    localparam int REMW = MAGW + 1;
    localparam int NS   = QB + 1;

    logic                   v_reg   [NS+1];
    logic [MAGW-1:0]        d_reg   [NS+1];
    logic                   sg_reg  [NS+1];
    logic [REMW-1:0]        rem_reg [NS+1][3];
    logic [MAGW+FRAC_BITS-1:0] n_reg [NS+1][3];
    logic [QB-1:0]          q_reg   [NS+1][3];
    logic                   neg_reg [NS+1][3];
    logic                   big_reg [NS+1][3];
    logic                   adv;
    logic                   dneg;
    logic [MAGW-1:0]        dmag;
    logic signed [PROD_W-1:0] nums [3];
    logic signed [DATA_W-1:0] sol_reg [3];
    logic                   sing_reg, sat_reg, ov_reg;

    assign adv       = !ov_reg || out_ready;
    assign job_ready = adv;
    assign nums[0] = job.num0;
    assign nums[1] = job.num1;
    assign nums[2] = job.num2;
    assign dneg = job.det[PROD_W-1];
    assign dmag = dneg ? MAGW'(-job.det) : MAGW'(job.det);

    // Entry stage: magnitudes, overflow precheck.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0]  <= dmag;
            sg_reg[0] <= job.det == '0;
            for (int k = 0; k < 3; k++)
            begin
                logic [MAGW-1:0] nm;
                nm = nums[k][PROD_W-1] ? MAGW'(-nums[k]) : MAGW'(nums[k]);
                neg_reg[0][k] <= nums[k][PROD_W-1] ^ dneg;
                n_reg[0][k]   <= {nm, {FRAC_BITS{1'b0}}};
                big_reg[0][k] <= {nm, {FRAC_BITS{1'b0}}} >= {dmag, {QB{1'b0}}};
                rem_reg[0][k] <= '0;
                q_reg[0][k]   <= '0;
            end
        end
    end

    // Long division: high bits of the shifted numerator are rem start; each later stage one bit.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NS; s++)
            begin
                d_reg[s+1]  <= d_reg[s];
                sg_reg[s+1] <= sg_reg[s];
                for (int k = 0; k < 3; k++)
                begin
                    logic [REMW-1:0] r;
                    logic [REMW:0]   t;
                    neg_reg[s+1][k] <= neg_reg[s][k];
                    big_reg[s+1][k] <= big_reg[s][k];
                    if (s == 0)
                    begin
                        // Upper part: everything above quotient bit QB-1; below |d| if not big.
                        r = REMW'(n_reg[s][k] >> QB);
                        rem_reg[s+1][k] <= big_reg[s][k] ? '0 : r;
                        n_reg[s+1][k]   <= n_reg[s][k];
                        q_reg[s+1][k]   <= '0;
                    end
                    else
                    begin
                        r = {rem_reg[s][k][REMW-2:0], n_reg[s][k][QB-s]};
                        t = {1'b0, r} - {2'b0, d_reg[s]};
                        n_reg[s+1][k] <= n_reg[s][k];
                        if (!t[REMW])
                        begin
                            rem_reg[s+1][k] <= t[REMW-1:0];
                            q_reg[s+1][k]   <= {q_reg[s][k][QB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[s+1][k] <= r;
                            q_reg[s+1][k]   <= {q_reg[s][k][QB-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    end

    // Output register: sign, saturation, singular override.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic sat;
            sat = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                logic [QB-1:0] q;
                q = q_reg[NS][k];
                if (sg_reg[NS])
                    sol_reg[k] <= '0;
                else if (neg_reg[NS][k])
                begin
                    if (big_reg[NS][k] || q > 32'h8000_0000)
                    begin
                        sol_reg[k] <= 32'sh8000_0000;
                        sat = 1'b1;
                    end
                    else
                        sol_reg[k] <= DATA_W'(-q);
                end
                else if (big_reg[NS][k] || q[QB-1])
                begin
                    sol_reg[k] <= 32'sh7FFF_FFFF;
                    sat = 1'b1;
                end
                else
                    sol_reg[k] <= DATA_W'(q);
            end
            sing_reg <= sg_reg[NS];
            sat_reg  <= sat && !sg_reg[NS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
                v_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= job_valid;
            for (int s = 0; s < NS; s++)
                v_reg[s+1] <= v_reg[s];
            ov_reg <= v_reg[NS];
        end
    end

    assign out_valid = ov_reg;
    assign sol       = sol_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;
endmodule
`default_nettype wire

@@ rtl/core/transposed_3x3_linear_solver.sv @@
// Transposed 3x3 linear solver: solves transpose(M) x = rhs by Cramer's rule in
// fixed point with FRAC_BITS fraction bits, one beat in and one beat out per cycle at
// full rate. A result passes four front stages for the exact 97-bit determinant and
// numerators, a register in the two-entry queue, then 35 back-end stages (entry, one
// upper-part stage, 32 restoring-division stages of one quotient bit each, output
// register). Output back-pressure stalls the back end; the queue lets the front end
// run on for two more beats before input stalls. Quotients truncate toward zero and
// saturate; a zero determinant gives zero outputs with singular set.
`default_nettype none
module transposed_3x3_linear_solver
    import t3ls_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire signed [DATA_W-1:0]  elem_0, elem_1, elem_2, elem_3, elem_4,
    input  wire signed [DATA_W-1:0]  elem_5, elem_6, elem_7, elem_8,
    input  wire signed [DATA_W-1:0]  rhs_0, rhs_1, rhs_2,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic signed [DATA_W-1:0] sol_0, sol_1, sol_2,
    output logic                     singular,
    output logic                     saturated
);
    logic signed [DATA_W-1:0] m [9];
    logic signed [DATA_W-1:0] b [3];
    logic signed [DATA_W-1:0] s [3];
    t3ls_job_t fj, qj;
    logic      fv, fr, qv, qr;

    assign m = '{elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6, elem_7, elem_8};
    assign b = '{rhs_0, rhs_1, rhs_2};

    t3ls_front u_front (.clk, .rst_n, .in_valid, .in_ready, .m, .b,
        .job_valid(fv), .job_ready(fr), .job(fj));

    t3ls_queue u_queue (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qj));

    t3ls_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk, .rst_n, .job_valid(qv), .job_ready(qr),
        .job(qj), .out_valid, .out_ready, .sol(s), .singular, .saturated);

    assign sol_0 = s[0];
    assign sol_1 = s[1];
    assign sol_2 = s[2];

    // A singular result never reports saturation and carries zero solutions.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated && sol_0 == '0 && sol_1 == '0 && sol_2 == '0)
        else $error("singular result with nonzero outputs");

    // A queue that refuses a front-end beat is never empty.
    assert property (@(posedge clk) disable iff (!rst_n) fv && !fr |-> qv)
        else $error("queue full while empty");
endmodule
`default_nettype wire

@@ verif/transposed_3x3_linear_solver_tb.sv @@
// Testbench for the transposed 3x3 linear solver: drives matrix and right-hand side beats
// with random idling and back-pressure, predicts each solution exactly and checks it.
// Depends on t3ls_pkg and transposed_3x3_linear_solver.
`timescale 1ns / 100ps
`default_nettype none
module transposed_3x3_linear_solver_tb;
    import t3ls_pkg::*;

    localparam int FRAC = DEFAULT_FRAC_BITS;
    localparam int N_RANDOM = 1530;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] wide_t;

    typedef struct {
        word_t m[9];
        word_t b[3];
    } system_t;

    typedef struct {
        word_t x[3];
        logic  sing;
        logic  sat;
    } solution_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    word_t elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6, elem_7, elem_8;
    word_t rhs_0, rhs_1, rhs_2;
    logic out_valid;
    logic out_ready;
    word_t sol_0, sol_1, sol_2;
    logic singular;
    logic saturated;

    system_t pending_systems[$];
    solution_t expected_solutions[$];
    idle_mode_t idle_mode;
    logic stimulus_done;
    logic hold_request;
    logic in_taken;
    int hold_count;
    int mismatches = 0;

    transposed_3x3_linear_solver #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
        .elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6), .elem_7(elem_7),
        .elem_8(elem_8), .rhs_0(rhs_0), .rhs_1(rhs_1), .rhs_2(rhs_2),
        .out_valid(out_valid), .out_ready(out_ready),
        .sol_0(sol_0), .sol_1(sol_1), .sol_2(sol_2),
        .singular(singular), .saturated(saturated)
    );

    // Clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Determinant of a row-major 3x3 matrix, exact at the full product width.
    function automatic wide_t det_of(input word_t t[9]);
        wide_t d;
        begin
            d = wide_t'(t[0]) * wide_t'(t[4]) * wide_t'(t[8])
              - wide_t'(t[0]) * wide_t'(t[5]) * wide_t'(t[7])
              - wide_t'(t[1]) * wide_t'(t[3]) * wide_t'(t[8])
              + wide_t'(t[1]) * wide_t'(t[5]) * wide_t'(t[6])
              + wide_t'(t[2]) * wide_t'(t[3]) * wide_t'(t[7])
              - wide_t'(t[2]) * wide_t'(t[4]) * wide_t'(t[6]);
            det_of = d;
        end
    endfunction

    // Scaled quotient, truncated toward zero, clamped to the word range.
    function automatic word_t scaled_quotient(input wide_t num, input wide_t den,
                                              inout logic sat);
        logic [PROD_W+FRAC:0] n_mag;
        logic [PROD_W+FRAC:0] d_mag;
        logic [PROD_W+FRAC:0] q;
        logic neg;
        begin
            neg = num[PROD_W-1] ^ den[PROD_W-1];
            n_mag = num[PROD_W-1] ? (PROD_W+FRAC+1)'(-num) : (PROD_W+FRAC+1)'(num);
            d_mag = den[PROD_W-1] ? (PROD_W+FRAC+1)'(-den) : (PROD_W+FRAC+1)'(den);
            q = (n_mag << FRAC) / d_mag;
            if (neg)
            begin
                if (q > 33'h0_8000_0000)
                begin
                    sat = 1'b1;
                    scaled_quotient = 32'sh8000_0000;
                end
                else
                begin
                    scaled_quotient = word_t'(-q[31:0]);
                end
            end
            else
            begin
                if (q > 33'h0_7FFF_FFFF)
                begin
                    sat = 1'b1;
                    scaled_quotient = 32'sh7FFF_FFFF;
                end
                else
                begin
                    scaled_quotient = word_t'(q[31:0]);
                end
            end
        end
    endfunction

    // Solves transpose(M) x = b by Cramer's rule.
    function automatic solution_t solve_transposed(input system_t s);
        word_t t[9];
        word_t w[9];
        wide_t d;
        solution_t r;
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    t[i*3+j] = s.m[j*3+i];
            d = det_of(t);
            r.sing = (d == '0);
            r.sat = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                r.x[k] = '0;
                if (!r.sing)
                begin
                    w = t;
                    for (int i = 0; i < 3; i++)
                        w[i*3+k] = s.b[i];
                    r.x[k] = scaled_quotient(det_of(w), d, r.sat);
                end
            end
            solve_transposed = r;
        end
    endfunction

    // Random word: modest magnitudes half the time, else full range or extremes.
    function automatic word_t rand_word();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                rand_word = word_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            else if (pick < 8)
                rand_word = word_t'($urandom);
            else if (pick == 8)
                rand_word = 32'sh8000_0000;
            else
                rand_word = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh0;
        end
    endfunction

    function automatic system_t rand_system();
        system_t s;
        int kind;
        begin
            foreach (s.m[i]) s.m[i] = rand_word();
            foreach (s.b[i]) s.b[i] = rand_word();
            kind = $urandom_range(0, 9);
            // Some matrices are made singular by repeating a row or column.
            if (kind == 0)
            begin
                for (int j = 0; j < 3; j++) s.m[6+j] = s.m[j];
            end
            else if (kind == 1)
            begin
                for (int i = 0; i < 3; i++) s.m[i*3+2] = s.m[i*3];
            end
            else if (kind < 4)
            begin
                // Well-conditioned: scaled identity plus small noise.
                for (int i = 0; i < 9; i++)
                    s.m[i] = word_t'($signed($urandom_range(0, 512)) - 256);
                for (int i = 0; i < 3; i++)
                    s.m[i*4] = word_t'($signed($urandom_range(1, 32'h0008_0000)));
            end
            rand_system = s;
        end
    endfunction

    function automatic system_t make_system(input word_t v, input word_t diag, input word_t rv);
        system_t s;
        begin
            foreach (s.m[i]) s.m[i] = v;
            for (int i = 0; i < 3; i++) s.m[i*4] = diag;
            foreach (s.b[i]) s.b[i] = rv;
            make_system = s;
        end
    endfunction

    // Stimulus: directed systems first, then random ones in idling phases.
    initial
    begin
        system_t s;
        stimulus_done = 1'b0;
        idle_mode = IDLE_NONE;
        hold_request = 1'b0;
        // Identity: solution equals the right-hand side.
        pending_systems.push_back(make_system(32'sh0, 32'sh0001_0000, 32'sh0003_0000));
        pending_systems.push_back(make_system(32'sh0, 32'sh0001_0000, 32'sh7FFF_FFFF));
        pending_systems.push_back(make_system(32'sh0, 32'sh0001_0000, 32'sh8000_0000));
        // All-zero matrix and all-equal matrix are singular.
        pending_systems.push_back(make_system(32'sh0, 32'sh0, 32'sh0001_0000));
        pending_systems.push_back(make_system(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh1));
        // Tiny determinant with large right-hand side saturates both ways.
        pending_systems.push_back(make_system(32'sh0, 32'sh1, 32'sh7FFF_FFFF));
        pending_systems.push_back(make_system(32'sh0, 32'sh1, 32'sh8000_0000));
        pending_systems.push_back(make_system(32'sh0, -32'sh1, 32'sh7FFF_FFFF));
        // Extreme diagonals and negative results.
        pending_systems.push_back(make_system(32'sh0, 32'sh8000_0000, 32'sh8000_0000));
        pending_systems.push_back(make_system(32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000));
        pending_systems.push_back(make_system(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pending_systems.push_back(make_system(32'sh1, 32'sh0002_0000, -32'sh0001_0000));
        pending_systems.push_back(make_system(-32'sh1, 32'shFFFF_FFFF, 32'sh5555_AAAA));
        // Non-symmetric matrix so that the transpose matters.
        s = make_system(32'sh0, 32'sh0001_0000, 32'sh0001_0000);
        s.m[1] = 32'sh0002_0000;
        s.b[0] = 32'sh0005_0000;
        s.b[1] = -32'sh0001_8000;
        pending_systems.push_back(s);
        // Rounding toward zero: x = 1/3 and -1/3.
        s = make_system(32'sh0, 32'sh0003_0000, 32'sh0001_0000);
        s.b[1] = -32'sh0001_0000;
        pending_systems.push_back(s);
        // Random content in several idling phases.
        for (int p = 0; p < 4; p++)
        begin
            wait (pending_systems.size() == 0);
            idle_mode = idle_mode_t'(p);
            // In the receiver phase hold the output off long enough to fill the block.
            if (p == 2) hold_request = 1'b1;
            for (int i = 0; i < N_RANDOM / 4; i++)
                pending_systems.push_back(rand_system());
        end
        wait (pending_systems.size() == 0);
        stimulus_done = 1'b1;
    end

    // Driver: presents one beat at a time and holds it until accepted.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            elem_0 <= '0; elem_1 <= '0; elem_2 <= '0; elem_3 <= '0; elem_4 <= '0;
            elem_5 <= '0; elem_6 <= '0; elem_7 <= '0; elem_8 <= '0;
            rhs_0 <= '0; rhs_1 <= '0; rhs_2 <= '0;
        end
        else
        begin
            logic fire;
            logic go;
            system_t s;
            // Acceptance is taken from the rising edge, not from the current ready.
            fire = in_taken;
            if (fire) void'(pending_systems.pop_front());
            if (in_valid && !fire)
            begin
                go = 1'b1;
            end
            else
            begin
                go = (pending_systems.size() != 0) &&
                     !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 80) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20));
            end
            in_valid <= go;
            if (go)
            begin
                s = pending_systems[0];
                elem_0 <= s.m[0]; elem_1 <= s.m[1]; elem_2 <= s.m[2];
                elem_3 <= s.m[3]; elem_4 <= s.m[4]; elem_5 <= s.m[5];
                elem_6 <= s.m[6]; elem_7 <= s.m[7]; elem_8 <= s.m[8];
                rhs_0 <= s.b[0]; rhs_1 <= s.b[1]; rhs_2 <= s.b[2];
            end
        end
    end

    // Prediction on each accepted input beat.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            system_t s;
            s.m[0] = elem_0; s.m[1] = elem_1; s.m[2] = elem_2;
            s.m[3] = elem_3; s.m[4] = elem_4; s.m[5] = elem_5;
            s.m[6] = elem_6; s.m[7] = elem_7; s.m[8] = elem_8;
            s.b[0] = rhs_0; s.b[1] = rhs_1; s.b[2] = rhs_2;
            expected_solutions.push_back(solve_transposed(s));
        end
    end

    // Receiver back-pressure, with one long hold-off counted here.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_request && hold_count < HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 80);
                IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 20);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: compares each output beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            solution_t e;
            if (expected_solutions.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: output beat with no prediction waiting");
            end
            else
            begin
                e = expected_solutions.pop_front();
                if (sol_0 !== e.x[0] || sol_1 !== e.x[1] || sol_2 !== e.x[2] ||
                    singular !== e.sing || saturated !== e.sat)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: sol %h %h %h sing %b sat %b, expected %h %h %h %b %b",
                                 sol_0, sol_1, sol_2, singular, saturated,
                                 e.x[0], e.x[1], e.x[2], e.sing, e.sat);
                end
            end
        end
    end

    // Reset, then wait for the run to drain.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done);
        wait (expected_solutions.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_solutions.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Timeout.
    initial
    begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
